/* rtl/hbd_pkg.sv */
// Shared types and codes for the Huffman block decoder.
// No dependencies; the engine and the top level refer to it by scoped names.
`timescale 1ns / 1ps
package hbd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_BLOCK_END = 2'd1;
   localparam logic [1:0] KIND_TRUNCATED = 2'd2;
   localparam logic [1:0] KIND_BAD_LEN   = 2'd3;

   // Width of a node number and of a symbol
   localparam int NODE_W = 8;

   // One input byte with its end-of-stream mark
   typedef struct packed {
      logic       eos;
      logic [7:0] data;
   } in_item_type;

   // One result item
   typedef struct packed {
      logic       last;
      logic [1:0] kind;
      logic [7:0] value;
   } rsp_item_type;

endpackage

/* rtl/hbd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module hbd_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/hbd_fifo.sv */
// Small register FIFO used for the byte queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps
module hbd_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/hbd_engine.sv */
// Back end of the decoder: bit-serial header, tree build and tree walk.
// Depends on hbd_pkg and hbd_ram (node memory and build stack).
`timescale 1ns / 1ps
module hbd_engine #(
   parameter int INTERNAL_NODES = 255,
   parameter int STACK_DEPTH    = 256,
   localparam int SLOT_W = (2 * INTERNAL_NODES > 1) ? $clog2(2 * INTERNAL_NODES) : 1,
   localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   localparam int TOP_W  = $clog2(STACK_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  hbd_pkg::in_item_type in_item,
   output logic                 in_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output hbd_pkg::rsp_item_type out_item
);

   // Sequencer states
   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_BIT    = 3'd1;
   localparam logic [2:0] S_POPRD  = 3'd2;
   localparam logic [2:0] S_PUSH2  = 3'd3;
   localparam logic [2:0] S_WALKRD = 3'd4;
   localparam logic [2:0] S_DONE1  = 3'd5;
   localparam logic [2:0] S_END    = 3'd6;
   localparam logic [2:0] S_FLUSH  = 3'd7;

   // Stream phases
   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_LEN8  = 3'd2;
   localparam logic [2:0] PH_LEN16 = 3'd3;
   localparam logic [2:0] PH_LEN32 = 3'd4;
   localparam logic [2:0] PH_TREE  = 3'd5;
   localparam logic [2:0] PH_LEAF  = 3'd6;
   localparam logic [2:0] PH_WALK  = 3'd7;

   localparam int NW = hbd_pkg::NODE_W;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        phase_ff, phase_in;
   logic [31:0]       len_ff, len_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [31:0]       left_ff, left_in;
   logic [NW-1:0]     nodes_ff, nodes_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic [NW-1:0]     walk_ff, walk_in;
   logic [7:0]        leaf_ff, leaf_in;
   logic [7:0]        byte_ff, byte_in;
   logic              eos_ff, eos_in;
   logic [2:0]        bit_ff, bit_in;
   logic              pop_leaf_ff, pop_leaf_in;
   logic [SA_W-1:0]   push_addr_ff, push_addr_in;
   logic [SLOT_W-1:0] push_data_ff, push_data_in;
   logic              pend_v_ff, pend_v_in;
   logic [1:0]        pend_kind_ff, pend_kind_in;
   logic [7:0]        pend_val_ff, pend_val_in;

   logic              go, b, do_adv, do_brk, do_clear, last_len;
   logic              emit_v, flush_v;
   logic [1:0]        emit_kind;
   logic [7:0]        emit_val;
   logic [31:0]       len_next;
   logic [5:0]        len_last;
   logic [TOP_W-1:0]  top_dec;
   logic [SLOT_W-1:0] pop_slot;
   logic [7:0]        leaf_next;

   logic              sw_en, sr_en, nw_en, nr_en;
   logic [SA_W-1:0]   sw_addr, sr_addr;
   logic [SLOT_W-1:0] sw_data, sr_data, nw_addr, nr_addr;
   logic [NW:0]       nw_data, nr_data;

   assign go       = !out_full;
   assign b        = byte_ff[bit_ff];
   assign top_dec  = top_ff - 1'b1;
   assign pop_slot = sr_data;
   assign len_next = len_ff | (32'(b) << cnt_ff);
   assign leaf_next = leaf_ff | (8'(b) << cnt_ff[2:0]);

   always_comb begin
      unique case (phase_ff)
         PH_LEN8:  len_last = 6'd7;
         PH_LEN16: len_last = 6'd15;
         default:  len_last = 6'd31;
      endcase
   end
   assign last_len = (cnt_ff == len_last);

   // Sequence one bit step per pass
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      left_in      = left_ff;
      nodes_in     = nodes_ff;
      top_in       = top_ff;
      walk_in      = walk_ff;
      leaf_in      = leaf_ff;
      byte_in      = byte_ff;
      eos_in       = eos_ff;
      bit_in       = bit_ff;
      pop_leaf_in  = pop_leaf_ff;
      push_addr_in = push_addr_ff;
      push_data_in = push_data_ff;
      in_pop       = 1'b0;
      do_adv       = 1'b0;
      do_brk       = 1'b0;
      do_clear     = 1'b0;
      emit_v       = 1'b0;
      emit_kind    = hbd_pkg::KIND_BYTE;
      emit_val     = '0;
      flush_v      = 1'b0;
      sw_en        = 1'b0;
      sw_addr      = '0;
      sw_data      = '0;
      sr_en        = 1'b0;
      sr_addr      = top_dec[SA_W-1:0];
      nw_en        = 1'b0;
      nw_addr      = pop_slot;
      nw_data      = '0;
      nr_en        = 1'b0;
      nr_addr      = SLOT_W'({walk_ff, b});

      if (go) begin
         unique case (state_ff)
            S_LOAD: begin
               if (in_valid) begin
                  in_pop   = 1'b1;
                  byte_in  = in_item.data;
                  eos_in   = in_item.eos;
                  bit_in   = '0;
                  state_in = S_BIT;
               end
            end
            S_BIT: begin
               unique case (phase_ff) inside
                  PH_HDR0: begin
                     len_in   = '0;
                     cnt_in   = '0;
                     phase_in = b ? PH_HDR1 : PH_LEN8;
                     do_adv   = 1'b1;
                  end
                  PH_HDR1: begin
                     phase_in = b ? PH_LEN32 : PH_LEN16;
                     do_adv   = 1'b1;
                  end
                  PH_LEN8, PH_LEN16, PH_LEN32: begin
                     len_in = len_next;
                     cnt_in = cnt_ff + 1'b1;
                     if (!last_len) begin
                        do_adv = 1'b1;
                     end else if (len_next[31]) begin
                        emit_v    = 1'b1;
                        emit_kind = hbd_pkg::KIND_BAD_LEN;
                        do_clear  = 1'b1;
                        do_brk    = 1'b1;
                     end else begin
                        // Seed the stack with the root's two child slots
                        left_in      = len_next;
                        len_in       = '0;
                        cnt_in       = '0;
                        nodes_in     = NW'(1);
                        top_in       = TOP_W'(2);
                        sw_en        = 1'b1;
                        sw_addr      = '0;
                        sw_data      = SLOT_W'(1);
                        push_addr_in = SA_W'(1);
                        push_data_in = '0;
                        phase_in     = PH_TREE;
                        state_in     = S_PUSH2;
                     end
                  end
                  PH_TREE: begin
                     if (top_ff == '0) begin
                        if (left_ff == '0) begin
                           emit_v    = 1'b1;
                           emit_kind = hbd_pkg::KIND_BLOCK_END;
                           do_clear  = 1'b1;
                           do_brk    = 1'b1;
                        end else begin
                           walk_in  = '0;
                           phase_in = PH_WALK;
                           do_adv   = 1'b1;
                        end
                     end else if (b) begin
                        leaf_in  = '0;
                        cnt_in   = '0;
                        phase_in = PH_LEAF;
                        do_adv   = 1'b1;
                     end else if (nodes_ff >= NW'(INTERNAL_NODES) ||
                                  top_ff == TOP_W'(STACK_DEPTH)) begin
                        emit_v    = 1'b1;
                        emit_kind = hbd_pkg::KIND_BAD_LEN;
                        do_clear  = 1'b1;
                        do_brk    = 1'b1;
                     end else begin
                        sr_en       = 1'b1;
                        pop_leaf_in = 1'b0;
                        state_in    = S_POPRD;
                     end
                  end
                  PH_LEAF: begin
                     leaf_in = leaf_next;
                     cnt_in  = cnt_ff + 1'b1;
                     if (cnt_ff[2:0] == 3'd7) begin
                        sr_en       = 1'b1;
                        pop_leaf_in = 1'b1;
                        state_in    = S_POPRD;
                     end else begin
                        do_adv = 1'b1;
                     end
                  end
                  default: begin
                     nr_en    = 1'b1;
                     state_in = S_WALKRD;
                  end
               endcase
            end
            S_POPRD: begin
               nw_en = 1'b1;
               if (pop_leaf_ff) begin
                  // Close a leaf: store its symbol and drop the slot
                  nw_data  = {1'b1, leaf_ff};
                  top_in   = top_dec;
                  cnt_in   = '0;
                  leaf_in  = '0;
                  phase_in = PH_TREE;
                  if (top_dec == '0) begin
                     if (left_ff == '0) begin
                        emit_v    = 1'b1;
                        emit_kind = hbd_pkg::KIND_BLOCK_END;
                        do_clear  = 1'b1;
                        do_brk    = 1'b1;
                     end else begin
                        walk_in  = '0;
                        phase_in = PH_WALK;
                        do_adv   = 1'b1;
                     end
                  end else begin
                     do_adv = 1'b1;
                  end
               end else begin
                  // Link a new internal node and push its two child slots
                  nw_data      = {1'b0, nodes_ff};
                  nodes_in     = nodes_ff + 1'b1;
                  sw_en        = 1'b1;
                  sw_addr      = top_dec[SA_W-1:0];
                  sw_data      = SLOT_W'({nodes_ff, 1'b1});
                  push_addr_in = top_ff[SA_W-1:0];
                  push_data_in = SLOT_W'({nodes_ff, 1'b0});
                  top_in       = top_ff + 1'b1;
                  state_in     = S_PUSH2;
               end
            end
            S_PUSH2: begin
               sw_en   = 1'b1;
               sw_addr = push_addr_ff;
               sw_data = push_data_ff;
               do_adv  = 1'b1;
            end
            S_WALKRD: begin
               if (nr_data[NW]) begin
                  emit_v    = 1'b1;
                  emit_kind = hbd_pkg::KIND_BYTE;
                  emit_val  = nr_data[7:0];
                  walk_in   = '0;
                  left_in   = left_ff - 1'b1;
                  if (left_ff == 32'd1) begin
                     state_in = S_DONE1;
                  end else begin
                     do_adv = 1'b1;
                  end
               end else begin
                  walk_in = nr_data[NW-1:0];
                  do_adv  = 1'b1;
               end
            end
            S_DONE1: begin
               emit_v    = 1'b1;
               emit_kind = hbd_pkg::KIND_BLOCK_END;
               do_clear  = 1'b1;
               do_brk    = 1'b1;
            end
            S_END: begin
               if (eos_ff) begin
                  if (phase_ff != PH_HDR0) begin
                     emit_v    = 1'b1;
                     emit_kind = hbd_pkg::KIND_TRUNCATED;
                  end
                  do_clear = 1'b1;
               end
               state_in = S_FLUSH;
            end
            default: begin
               flush_v  = 1'b1;
               state_in = S_LOAD;
            end
         endcase

         // Drop block state on error, completion or end of stream
         if (do_clear) begin
            phase_in = PH_HDR0;
            len_in   = '0;
            cnt_in   = '0;
            left_in  = '0;
            nodes_in = '0;
            top_in   = '0;
            walk_in  = '0;
            leaf_in  = '0;
         end
         if (do_brk) begin
            state_in = S_END;
         end else if (do_adv) begin
            bit_in   = bit_ff + 1'b1;
            state_in = (bit_ff == 3'd7) ? S_END : S_BIT;
         end
      end
   end

   // Hold one result back so the last one of a byte can be marked
   always_comb begin
      pend_v_in    = pend_v_ff;
      pend_kind_in = pend_kind_ff;
      pend_val_in  = pend_val_ff;
      out_push     = 1'b0;
      out_item     = '{last: flush_v, kind: pend_kind_ff, value: pend_val_ff};
      if (emit_v) begin
         out_push     = pend_v_ff;
         pend_v_in    = 1'b1;
         pend_kind_in = emit_kind;
         pend_val_in  = emit_val;
      end else if (flush_v) begin
         out_push  = pend_v_ff;
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         phase_ff  <= PH_HDR0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         left_ff   <= '0;
         nodes_ff  <= '0;
         top_ff    <= '0;
         walk_ff   <= '0;
         leaf_ff   <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
         nodes_ff  <= nodes_in;
         top_ff    <= top_in;
         walk_ff   <= walk_in;
         leaf_ff   <= leaf_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      eos_ff       <= eos_in;
      bit_ff       <= bit_in;
      pop_leaf_ff  <= pop_leaf_in;
      push_addr_ff <= push_addr_in;
      push_data_ff <= push_data_in;
      pend_kind_ff <= pend_kind_in;
      pend_val_ff  <= pend_val_in;
   end

   // Tree node memory: two child slots per internal node
   hbd_ram #(.WIDTH(NW + 1), .DEPTH(2 * INTERNAL_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (nw_en),
      .wr_addr (nw_addr),
      .wr_data (nw_data),
      .rd_en   (nr_en),
      .rd_addr (nr_addr),
      .rd_data (nr_data)
   );

   // Build stack of child slots still to be filled
   hbd_ram #(.WIDTH(SLOT_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (sw_addr),
      .wr_data (sw_data),
      .rd_en   (sr_en),
      .rd_addr (sr_addr),
      .rd_data (sr_data)
   );

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(STACK_DEPTH))
      else $error("build stack pointer beyond depth");

   a_walk_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WALK && state_ff != S_DONE1 |-> left_ff != '0)
      else $error("walking with no symbols left");

   a_walkrd_src: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALKRD |-> $past(state_ff) == S_BIT || $past(state_ff) == S_WALKRD)
      else $error("walk read without a request");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into full queue");

endmodule

/* rtl/huffman_block_decoder.sv */
// Top level of the Huffman block decoder: byte queue, decode engine, result queue.
// Depends on hbd_pkg, hbd_fifo and hbd_engine.
`timescale 1ns / 1ps
// Packed bytes enter on req_ (tdata = byte, tlast = end of stream) and are read
// LSB first. Each bit of the header and of a tree leaf symbol is handled in the
// bit state, an internal tree node adds a stack read and then two stack writes
// on the single write port, the last length bit seeds the stack, a leaf close
// or a walk step waits on a registered read of the build stack or node memory,
// the end of a block after its last symbol has a state of its own, and each
// byte adds load, end-of-byte check and result marking steps.
// Results leave on rsp_ (tuser = kind, tdata = symbol, tlast = last result of
// that byte). A two-entry byte queue and a four-entry result queue let the
// input and output sides stall independently. No clearing pass after reset.
module huffman_block_decoder #(
   parameter int INTERNAL_NODES = 255,
   parameter int STACK_DEPTH    = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] value
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   hbd_pkg::in_item_type  req_item, eng_item;
   hbd_pkg::rsp_item_type eng_rsp, out_rsp;
   logic in_full, in_ne, eng_pop, out_full, eng_push;

   assign req_item   = '{eos: req_tlast, data: req_tdata};
   assign req_tready = !in_full;

   // Byte queue in front of the engine
   hbd_fifo #(.WIDTH($bits(hbd_pkg::in_item_type)), .DEPTH(2)) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (req_item),
      .full      (in_full),
      .pop       (eng_pop),
      .pop_data  (eng_item),
      .not_empty (in_ne)
   );

   hbd_engine #(.INTERNAL_NODES(INTERNAL_NODES), .STACK_DEPTH(STACK_DEPTH)) u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_ne),
      .in_item  (eng_item),
      .in_pop   (eng_pop),
      .out_full (out_full),
      .out_push (eng_push),
      .out_item (eng_rsp)
   );

   // Result queue toward the consumer
   hbd_fifo #(.WIDTH($bits(hbd_pkg::rsp_item_type)), .DEPTH(4)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_rsp),
      .full      (out_full),
      .pop       (rsp_tready),
      .pop_data  (out_rsp),
      .not_empty (rsp_tvalid)
   );

   assign rsp_tdata = out_rsp.value;
   assign rsp_tuser = out_rsp.kind;
   assign rsp_tlast = out_rsp.last;

endmodule
